// ===== src/ipgs_pkg.sv =====
`timescale 1ns / 1ps
package ipgs_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_ADDR_W     = 5;
    localparam int PWM_OFFSET     = 600;
    localparam int PWM_MAX        = 65535;

    typedef enum logic [2:0] {
        REG_SETPOINT,
        REG_KP_BASE,
        REG_KI_TERM_BASE,
        REG_KD_TERM,
        REG_RATE_WEIGHT,
        REG_DEAD_ZONE,
        REG_BOOST_THRESHOLD,
        REG_MODE
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ERR,
        S_CPL,
        S_RW_WAIT,
        S_DZ,
        S_GAIN,
        S_COEF1,
        S_COEF2,
        S_MA,
        S_MA_WAIT,
        S_MB,
        S_MB_WAIT,
        S_MC,
        S_MC_WAIT,
        S_CLAMP,
        S_PWM,
        S_PUSH
    } ctl_state_t;

endpackage

// ===== src/ipgs_in_if.sv =====
`timescale 1ns / 1ps
interface ipgs_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] angle;
    logic signed [31:0] body_rate;
    logic signed [31:0] coupling;
    logic signed [31:0] upper_limit;
    logic signed [31:0] lower_limit;

    modport source (
        output valid, angle, body_rate, coupling, upper_limit, lower_limit,
        input  ready
    );

    modport sink (
        input  valid, angle, body_rate, coupling, upper_limit, lower_limit,
        output ready
    );
endinterface

// ===== src/ipgs_out_if.sv =====
`timescale 1ns / 1ps
interface ipgs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;
    logic        [15:0] pwm;

    modport source (
        output valid, drive, pwm,
        input  ready
    );

    modport sink (
        input  valid, drive, pwm,
        output ready
    );
endinterface

// ===== src/ipgs_ser_mul.sv =====
`timescale 1ns / 1ps
module ipgs_ser_mul
    import ipgs_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DATA_WIDTH-1:0] x,
    input  logic signed [DATA_WIDTH-1:0] y,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] p
);

    localparam int DW  = DATA_WIDTH;
    localparam int ND  = (DW + 1) / 2;
    localparam int MW  = 2 * ND;
    localparam int PW  = DW + MW;
    localparam int QW  = PW - FRAC_BITS;
    localparam int QCW = (QW > DW ? QW : DW) + 1;
    localparam int CW  = $clog2(ND + 1);
    localparam logic [QCW-1:0] LIM_NEG = QCW'(1) << (DW - 1);
    localparam logic [QCW-1:0] LIM_POS = LIM_NEG - QCW'(1);

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic [DW-1:0] mx_reg, mx_next;
    logic [DW+1:0] mx3_reg, mx3_next;
    logic [DW+1:0] hi_reg, hi_next;
    logic [MW-1:0] y_reg, y_next;
    logic [DW-1:0] p_reg, p_next;
    logic [DW-1:0] mag_x, mag_y;
    logic [DW+1:0] addend, sum;
    logic [PW-1:0] prod;
    logic [QCW-1:0] q, lim, qs;

    always_comb
    begin
        mag_x = x[DW-1] ? (~x + 1'b1) : x;
        mag_y = y[DW-1] ? (~y + 1'b1) : y;

        case (y_reg[1:0])
            2'd0:    addend = '0;
            2'd1:    addend = {2'b00, mx_reg};
            2'd2:    addend = {1'b0, mx_reg, 1'b0};
            default: addend = mx3_reg;
        endcase
        sum = hi_reg + addend;

        prod = {hi_reg[DW-1:0], y_reg};
        q    = QCW'(prod[PW-1:FRAC_BITS]);
        lim  = neg_reg ? LIM_NEG : LIM_POS;
        qs   = (q > lim) ? lim : q;

        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        mx_next   = mx_reg;
        mx3_next  = mx3_reg;
        hi_next   = hi_reg;
        y_next    = y_reg;
        p_next    = p_reg;

        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CW'(ND);
            neg_next = x[DW-1] ^ y[DW-1];
            mx_next  = mag_x;
            mx3_next = {2'b00, mag_x} + {1'b0, mag_x, 1'b0};
            hi_next  = '0;
            y_next   = MW'(mag_y);
        end
        else if (run_reg)
        begin
            if (cnt_reg != '0)
            begin
                hi_next  = {2'b00, sum[DW+1:2]};
                y_next   = {sum[1:0], y_reg[MW-1:2]};
                cnt_next = cnt_reg - 1'b1;
            end
            else
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
                p_next    = neg_reg ? (~qs[DW-1:0] + 1'b1) : qs[DW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mx_reg  <= mx_next;
        mx3_reg <= mx3_next;
        hi_reg  <= hi_next;
        y_reg   <= y_next;
        p_reg   <= p_next;
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

// ===== src/incremental_pid_gain_scheduled.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake      Payload
// -------  ---  -------------  ------------------------------------------------
// sample   in   valid / ready  angle, body_rate, coupling, upper_limit, lower_limit
// result   out  valid / ready  drive, pwm
// apb      in   psel/penable   8 registers at 4*i, pready tied high
//
// One beat at a time: no new sample is taken until the current result is loaded out.
// Products run on the shared radix-4 serial multiplier, 2 multiplier bits per cycle:
// 4 products in mode 1, 3 in mode 0.
// Reset clears error history, previous output and config registers, but sets the
// boost threshold to all ones and mode to 1; no clearing pass.
// A result waits in the output register; the next sample is taken while it waits.
module incremental_pid_gain_scheduled
    import ipgs_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    ipgs_in_if.sink               sample,
    ipgs_out_if.source            result
);

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int EW = (DW > 32 ? DW : 32) + 2;
    localparam int VW = (DW + 8 > FB + 10 ? DW + 8 : FB + 10) + 2;
    localparam logic signed [EW-1:0] VMAX_E = signed'(EW'({(DW-1){1'b1}}));
    localparam logic signed [EW-1:0] VMIN_E = ~VMAX_E;
    localparam logic signed [VW-1:0] PWM_OFF_V = signed'(VW'(PWM_OFFSET) << FB);
    localparam logic signed [VW-1:0] PWM_MAX_V = signed'(VW'(PWM_MAX));

    function automatic logic signed [DW-1:0] sat(input logic signed [EW-1:0] v);
        logic signed [DW-1:0] res;
        if (v > VMAX_E)
            res = VMAX_E[DW-1:0];
        else if (v < VMIN_E)
            res = VMIN_E[DW-1:0];
        else
            res = v[DW-1:0];
        return res;
    endfunction

    function automatic logic signed [EW-1:0] ext(input logic signed [DW-1:0] v);
        return EW'(v);
    endfunction

    function automatic logic signed [DW-1:0] in_sat(input logic signed [31:0] v);
        return sat(EW'(v));
    endfunction

    ctl_state_t state_reg, state_next;

    logic [31:0] setpoint_reg, kp_base_reg, ki_term_base_reg, kd_term_reg, rate_weight_reg;
    logic [30:0] dead_zone_reg, boost_threshold_reg;
    logic        mode_reg;
    logic        cfg_wr;
    cfg_reg_t    cfg_idx;

    logic signed [DW-1:0] sp_s, kp_base_s, ki_base_s, kd_s, rw_s;
    logic signed [EW-1:0] dz_e, bt_e;

    logic signed [DW-1:0] angle_reg, angle_next, rate_reg, rate_next, cpl_reg, cpl_next;
    logic signed [DW-1:0] upper_reg, upper_next, lower_reg, lower_next;
    logic signed [DW-1:0] e_reg, e_next, kp_reg, kp_next, ki_reg, ki_next;
    logic signed [DW-1:0] a_reg, a_next, b_reg, b_next, kd2_reg, kd2_next;
    logic signed [DW-1:0] r_reg, r_next;
    logic signed [DW-1:0] prev_out_reg, prev_out_next, prev_err_reg, prev_err_next;
    logic signed [DW-1:0] prev_prev_reg, prev_prev_next;
    logic        [15:0]   pwm_reg, pwm_next, pwm_out_reg, pwm_out_next;
    logic signed [31:0]   drive_out_reg, drive_out_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 in_acc, out_free, out_load;
    logic                 mul_start, mul_done;
    logic signed [DW-1:0] mul_x, mul_y, mul_p;

    logic signed [EW-1:0] e_ext, e_mag;
    logic                 boost_en;
    logic signed [DW-1:0] kp_boost, ki_boost;
    logic signed [VW-1:0] rv, pv, pv_sh;
    logic        [15:0]   pwm_calc;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

    always_comb
    begin
        unique case (cfg_idx)
            REG_SETPOINT:        prdata = setpoint_reg;
            REG_KP_BASE:         prdata = kp_base_reg;
            REG_KI_TERM_BASE:    prdata = ki_term_base_reg;
            REG_KD_TERM:         prdata = kd_term_reg;
            REG_RATE_WEIGHT:     prdata = rate_weight_reg;
            REG_DEAD_ZONE:       prdata = {1'b0, dead_zone_reg};
            REG_BOOST_THRESHOLD: prdata = {1'b0, boost_threshold_reg};
            REG_MODE:            prdata = {31'b0, mode_reg};
        endcase
    end

    assign sp_s      = in_sat(setpoint_reg);
    assign kp_base_s = in_sat(kp_base_reg);
    assign ki_base_s = in_sat(ki_term_base_reg);
    assign kd_s      = in_sat(kd_term_reg);
    assign rw_s      = in_sat(rate_weight_reg);
    assign dz_e      = signed'(EW'(dead_zone_reg));
    assign bt_e      = signed'(EW'(boost_threshold_reg));

    // Handshake
    assign in_acc    = sample.valid && sample.ready;
    assign out_free  = !out_valid_reg || result.ready;
    assign result.valid = out_valid_reg;
    assign result.drive = drive_out_reg;
    assign result.pwm   = pwm_out_reg;

    ipgs_ser_mul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .done  (mul_done),
        .p     (mul_p)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (in_acc) state_next = S_ERR;
            S_ERR:     state_next = mode_reg ? S_CPL : S_DZ;
            S_CPL:     state_next = S_RW_WAIT;
            S_RW_WAIT: if (mul_done) state_next = S_DZ;
            S_DZ:      state_next = S_GAIN;
            S_GAIN:    state_next = S_COEF1;
            S_COEF1:   state_next = S_COEF2;
            S_COEF2:   state_next = S_MA;
            S_MA:      state_next = S_MA_WAIT;
            S_MA_WAIT: if (mul_done) state_next = S_MB;
            S_MB:      state_next = S_MB_WAIT;
            S_MB_WAIT: if (mul_done) state_next = S_MC;
            S_MC:      state_next = S_MC_WAIT;
            S_MC_WAIT: if (mul_done) state_next = S_CLAMP;
            S_CLAMP:   state_next = S_PWM;
            S_PWM:     state_next = S_PUSH;
            S_PUSH:    if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        sample.ready = 1'b0;
        out_load     = 1'b0;
        mul_start    = 1'b0;
        mul_x        = a_reg;
        mul_y        = e_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                sample.ready = 1'b1;
            end
            S_CPL:
            begin
                mul_start = 1'b1;
                mul_x     = rate_reg;
                mul_y     = rw_s;
            end
            S_MA:
            begin
                mul_start = 1'b1;
            end
            S_MB:
            begin
                mul_start = 1'b1;
                mul_x     = b_reg;
                mul_y     = prev_err_reg;
            end
            S_MC:
            begin
                mul_start = 1'b1;
                mul_x     = kd_s;
                mul_y     = prev_prev_reg;
            end
            S_PUSH:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // Datapath
    always_comb
    begin
        e_ext    = ext(e_reg);
        e_mag    = e_ext[EW-1] ? -e_ext : e_ext;
        boost_en = e_mag > bt_e;
        kp_boost = sat(ext(kp_base_s) + (ext(kp_base_s) >>> 1));
        ki_boost = sat(ext(ki_base_s) + (ext(ki_base_s) >>> 1));

        // x400 = x256 + x128 + x16
        rv       = VW'(r_reg);
        pv       = (rv <<< 8) + (rv <<< 7) + (rv <<< 4) + PWM_OFF_V;
        pv_sh    = pv >>> FB;
        if (pv[VW-1])
            pwm_calc = '0;
        else if (pv_sh > PWM_MAX_V)
            pwm_calc = 16'(PWM_MAX);
        else
            pwm_calc = pv_sh[15:0];

        angle_next     = angle_reg;
        rate_next      = rate_reg;
        cpl_next       = cpl_reg;
        upper_next     = upper_reg;
        lower_next     = lower_reg;
        e_next         = e_reg;
        kp_next        = kp_reg;
        ki_next        = ki_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        kd2_next       = kd2_reg;
        r_next         = r_reg;
        prev_out_next  = prev_out_reg;
        prev_err_next  = prev_err_reg;
        prev_prev_next = prev_prev_reg;
        pwm_next       = pwm_reg;
        drive_out_next = drive_out_reg;
        pwm_out_next   = pwm_out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        unique case (state_reg) inside
            S_IDLE:
            begin
                if (in_acc)
                begin
                    angle_next = in_sat(sample.angle);
                    rate_next  = in_sat(sample.body_rate);
                    cpl_next   = in_sat(sample.coupling);
                    upper_next = in_sat(sample.upper_limit);
                    lower_next = in_sat(sample.lower_limit);
                end
            end
            S_ERR:
            begin
                e_next = sat(ext(sp_s) - ext(angle_reg));
            end
            S_CPL:
            begin
                e_next = sat(e_ext + ext(cpl_reg));
            end
            S_RW_WAIT:
            begin
                if (mul_done)
                    e_next = sat(e_ext - ext(mul_p));
            end
            S_DZ:
            begin
                if (e_ext < dz_e && e_ext > -dz_e)
                    e_next = '0;
            end
            S_GAIN:
            begin
                kp_next = boost_en ? kp_boost : kp_base_s;
                ki_next = boost_en ? ki_boost : ki_base_s;
            end
            S_COEF1:
            begin
                a_next   = sat(ext(kp_reg) + ext(ki_reg));
                b_next   = sat(ext(ki_reg) - ext(kp_reg));
                kd2_next = sat(ext(kd_s) <<< 1);
            end
            S_COEF2:
            begin
                a_next = sat(ext(a_reg) + ext(kd_s));
                b_next = sat(ext(b_reg) - ext(kd2_reg));
            end
            S_MA_WAIT:
            begin
                if (mul_done)
                    r_next = sat(ext(prev_out_reg) + ext(mul_p));
            end
            S_MB_WAIT, S_MC_WAIT:
            begin
                if (mul_done)
                    r_next = sat(ext(r_reg) + ext(mul_p));
            end
            S_CLAMP:
            begin
                if (r_reg >= upper_reg)
                    r_next = upper_reg;
                else if (r_reg <= lower_reg)
                    r_next = lower_reg;
                prev_out_next  = r_next;
                prev_prev_next = prev_err_reg;
                prev_err_next  = e_reg;
            end
            S_PWM:
            begin
                pwm_next = pwm_calc;
            end
            S_PUSH:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    drive_out_next = 32'(r_reg);
                    pwm_out_next   = pwm_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            out_valid_reg       <= 1'b0;
            prev_out_reg        <= '0;
            prev_err_reg        <= '0;
            prev_prev_reg       <= '0;
            setpoint_reg        <= '0;
            kp_base_reg         <= '0;
            ki_term_base_reg    <= '0;
            kd_term_reg         <= '0;
            rate_weight_reg     <= '0;
            dead_zone_reg       <= '0;
            boost_threshold_reg <= '1;
            mode_reg            <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            prev_out_reg  <= prev_out_next;
            prev_err_reg  <= prev_err_next;
            prev_prev_reg <= prev_prev_next;
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    REG_SETPOINT:        setpoint_reg        <= pwdata;
                    REG_KP_BASE:         kp_base_reg         <= pwdata;
                    REG_KI_TERM_BASE:    ki_term_base_reg    <= pwdata;
                    REG_KD_TERM:         kd_term_reg         <= pwdata;
                    REG_RATE_WEIGHT:     rate_weight_reg     <= pwdata;
                    REG_DEAD_ZONE:       dead_zone_reg       <= pwdata[30:0];
                    REG_BOOST_THRESHOLD: boost_threshold_reg <= pwdata[30:0];
                    REG_MODE:            mode_reg            <= pwdata[0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg     <= angle_next;
        rate_reg      <= rate_next;
        cpl_reg       <= cpl_next;
        upper_reg     <= upper_next;
        lower_reg     <= lower_next;
        e_reg         <= e_next;
        kp_reg        <= kp_next;
        ki_reg        <= ki_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        kd2_reg       <= kd2_next;
        r_reg         <= r_next;
        pwm_reg       <= pwm_next;
        drive_out_reg <= drive_out_next;
        pwm_out_reg   <= pwm_out_next;
    end

endmodule
